/* hw/rtl/iadf_pkg.sv */
// ----------------------------------------------------------------------------
// iadf_pkg
// Shared types and constants for the IPv4/ARP destination redirect filter.
// ----------------------------------------------------------------------------
package iadf_pkg;

  localparam int unsigned CountW = 6;

  localparam logic [CountW-1:0] CountMax = 6'd63;

  localparam logic [15:0] EtypeIpv4 = 16'h0800;
  localparam logic [15:0] EtypeArp  = 16'h0806;

  // Byte offsets within the frame
  localparam logic [CountW-1:0] PosEtypeHi  = 6'd12;
  localparam logic [CountW-1:0] PosEtypeLo  = 6'd13;
  localparam logic [CountW-1:0] PosProtoHi  = 6'd16;
  localparam logic [CountW-1:0] PosProtoLo  = 6'd17;
  localparam logic [CountW-1:0] PosIpDstLo  = 6'd30;
  localparam logic [CountW-1:0] PosIpDstHi  = 6'd33;
  localparam logic [CountW-1:0] PosArpTpaLo = 6'd38;
  localparam logic [CountW-1:0] PosArpTpaHi = 6'd41;

  // Minimum frame length, compared against the last byte's offset
  localparam logic [CountW-1:0] LastPosIpv4 = 6'd33;
  localparam logic [CountW-1:0] LastPosArp  = 6'd41;

  localparam logic [7:0] RegMatchAddress  = 8'd0;
  localparam logic [7:0] RegTargetPresent = 8'd1;

  typedef enum logic [1:0] {
    KIND_OTHER = 2'd0,
    KIND_IPV4  = 2'd1,
    KIND_ARP   = 2'd2
  } frame_kind_t;

  typedef struct packed {
    logic [31:0] match_address;
    logic        target_present;
  } cfg_t;

  typedef struct packed {
    logic        verdict;
    frame_kind_t frame_kind;
  } result_t;

endpackage

/* hw/rtl/iadf_parser.sv */
// ----------------------------------------------------------------------------
// iadf_parser
// Tracks byte position and header fields of the current frame and forms the
// verdict for the frame's last byte.
// ----------------------------------------------------------------------------
module iadf_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              byte_accept,
  input  logic [7:0]        data_byte,
  input  logic              last_byte,
  input  iadf_pkg::cfg_t    cfg,
  output iadf_pkg::result_t result
);

  logic [iadf_pkg::CountW-1:0] byte_count_r, byte_count_nxt;
  logic [15:0]                 ether_type_r, ether_type_nxt;
  logic [15:0]                 arp_protocol_r, arp_protocol_nxt;
  logic [31:0]                 dest_address_r, dest_address_nxt;
  logic [iadf_pkg::CountW-1:0] pos;

  assign pos = byte_count_r;

  always_comb begin
    ether_type_nxt   = ether_type_r;
    arp_protocol_nxt = arp_protocol_r;
    dest_address_nxt = dest_address_r;
    if (pos == iadf_pkg::PosEtypeHi || pos == iadf_pkg::PosEtypeLo) begin
      ether_type_nxt = {ether_type_r[7:0], data_byte};
    end
    if (pos == iadf_pkg::PosProtoHi || pos == iadf_pkg::PosProtoLo) begin
      arp_protocol_nxt = {arp_protocol_r[7:0], data_byte};
    end
    // ether_type is already complete by the time the address bytes arrive
    if (pos inside {[iadf_pkg::PosIpDstLo:iadf_pkg::PosIpDstHi]} &&
        ether_type_r == iadf_pkg::EtypeIpv4) begin
      dest_address_nxt = {dest_address_r[23:0], data_byte};
    end
    if (pos inside {[iadf_pkg::PosArpTpaLo:iadf_pkg::PosArpTpaHi]} &&
        ether_type_r == iadf_pkg::EtypeArp) begin
      dest_address_nxt = {dest_address_r[23:0], data_byte};
    end
    byte_count_nxt = (byte_count_r == iadf_pkg::CountMax) ? byte_count_r
                                                          : byte_count_r + 1'b1;
  end

  // Classify from the updated fields, so the final byte itself counts
  always_comb begin
    result.frame_kind = iadf_pkg::KIND_OTHER;
    if (ether_type_nxt == iadf_pkg::EtypeIpv4 && pos >= iadf_pkg::LastPosIpv4) begin
      result.frame_kind = iadf_pkg::KIND_IPV4;
    end else if (ether_type_nxt == iadf_pkg::EtypeArp && pos >= iadf_pkg::LastPosArp &&
                 arp_protocol_nxt == iadf_pkg::EtypeIpv4) begin
      result.frame_kind = iadf_pkg::KIND_ARP;
    end
    result.verdict = (result.frame_kind != iadf_pkg::KIND_OTHER) &&
                     (dest_address_nxt == cfg.match_address) && cfg.target_present;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r   <= '0;
      ether_type_r   <= '0;
      arp_protocol_r <= '0;
      dest_address_r <= '0;
    end else if (byte_accept) begin
      if (last_byte) begin
        // clear for the next frame
        byte_count_r   <= '0;
        ether_type_r   <= '0;
        arp_protocol_r <= '0;
        dest_address_r <= '0;
      end else begin
        byte_count_r   <= byte_count_nxt;
        ether_type_r   <= ether_type_nxt;
        arp_protocol_r <= arp_protocol_nxt;
        dest_address_r <= dest_address_nxt;
      end
    end
  end

endmodule

/* hw/rtl/ipv4_arp_dest_redirect_filter.sv */
// ----------------------------------------------------------------------------
// ipv4_arp_dest_redirect_filter
// Per-frame redirect verdict from the IPv4 or ARP target destination address.
// ----------------------------------------------------------------------------
// The verdict is registered and appears in the cycle after the last byte's transaction.
// Throughput: one byte per cycle; the input stalls only while a verdict sits
// unaccepted in the output register and out_tready is low.
// Reset (rst_n low, synchronous): clears frame state, configuration and the
// output valid flag; the output data register is not reset.
module ipv4_arp_dest_redirect_filter (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // last_byte
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [0] verdict, [7:1] zero
  output logic [1:0]  out_tuser,  // [1:0] frame_kind
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  iadf_pkg::cfg_t    cfg_r;
  iadf_pkg::result_t result;
  iadf_pkg::result_t out_r;
  logic              out_valid_r;
  logic              in_accept;

  assign cfg_ready = 1'b1;
  assign in_tready = !out_valid_r || out_tready;
  assign in_accept = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        iadf_pkg::RegMatchAddress:  cfg_r.match_address  <= cfg_data;
        iadf_pkg::RegTargetPresent: cfg_r.target_present <= cfg_data[0];
        default: ;  // drop writes to unknown registers
      endcase
    end
  end

  iadf_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .byte_accept (in_accept),
    .data_byte   (in_tdata),
    .last_byte   (in_tlast),
    .cfg         (cfg_r),
    .result      (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept && in_tlast) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && in_tlast) begin
      out_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_r.verdict};
  assign out_tuser  = out_r.frame_kind;

  // Assertions

  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tlast) |=> out_tvalid)
    else $error("last byte accepted but no result presented");

  a_redirect_needs_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[0]) |-> (out_tuser != iadf_pkg::KIND_OTHER))
    else $error("redirect verdict on an unclassified frame");

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser != 2'd3))
    else $error("illegal frame kind");

  a_no_accept_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |-> !in_tready)
    else $error("input accepted while result is stalled");

endmodule
